// ===== src/nlsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nlsc_pkg
// Shared types and character codes for the number literal syntax checker.
// ----------------------------------------------------------------------------
package nlsc_pkg;

   localparam logic [7:0] CHAR_E     = 8'h65;  // lowercase 'e'
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 8;

   // Position in the decimal grammar, one-hot.
   typedef enum logic [10:0] {
      PH_START  = 11'b000_0000_0001,
      PH_PLUS   = 11'b000_0000_0010,
      PH_MINUS  = 11'b000_0000_0100,
      PH_INT    = 11'b000_0000_1000,
      PH_DOT    = 11'b000_0001_0000,
      PH_FRAC   = 11'b000_0010_0000,
      PH_E      = 11'b000_0100_0000,
      PH_EPLUS  = 11'b000_1000_0000,
      PH_EMINUS = 11'b001_0000_0000,
      PH_EXP    = 11'b010_0000_0000,
      PH_FAIL   = 11'b100_0000_0000
   } phase_type;

   // Outcome of one byte step.
   typedef struct packed {
      phase_type phase_next;
      logic      is_integer;
      logic      is_decimal;
   } step_type;

endpackage

// ===== src/nlsc_step.sv =====
// ----------------------------------------------------------------------------
// nlsc_step
// One byte of the grammar walk: next phase and the verdict if the string
// ended on this byte.
// ----------------------------------------------------------------------------
module nlsc_step (
   input  nlsc_pkg::phase_type phase,
   input  logic [7:0]          char_code,
   output nlsc_pkg::step_type  step
);
   import nlsc_pkg::*;

   logic      is_digit;
   phase_type nxt;

   always_comb begin
      is_digit = char_code inside {[CHAR_ZERO:CHAR_NINE]};
      nxt      = PH_FAIL;
      case (phase)
         PH_START: begin
            if (char_code == CHAR_PLUS)       nxt = PH_PLUS;
            else if (char_code == CHAR_MINUS) nxt = PH_MINUS;
            else if (is_digit)                nxt = PH_INT;
            else if (char_code == CHAR_DOT)   nxt = PH_DOT;
            else if (char_code == CHAR_E)     nxt = PH_E;
         end
         PH_PLUS: begin
            if (char_code == CHAR_MINUS)      nxt = PH_MINUS;
            else if (is_digit)                nxt = PH_INT;
            else if (char_code == CHAR_DOT)   nxt = PH_DOT;
            else if (char_code == CHAR_E)     nxt = PH_E;
         end
         PH_MINUS, PH_INT: begin
            if (is_digit)                     nxt = PH_INT;
            else if (char_code == CHAR_DOT)   nxt = PH_DOT;
            else if (char_code == CHAR_E)     nxt = PH_E;
         end
         PH_DOT, PH_FRAC: begin
            if (is_digit)                     nxt = PH_FRAC;
            else if (char_code == CHAR_E)     nxt = PH_E;
         end
         PH_E: begin
            if (char_code == CHAR_PLUS)       nxt = PH_EPLUS;
            else if (char_code == CHAR_MINUS) nxt = PH_EMINUS;
            else if (is_digit)                nxt = PH_EXP;
         end
         PH_EPLUS: begin
            if (char_code == CHAR_MINUS)      nxt = PH_EMINUS;
            else if (is_digit)                nxt = PH_EXP;
         end
         PH_EMINUS, PH_EXP: begin
            if (is_digit)                     nxt = PH_EXP;
         end
         default: begin
            nxt = PH_FAIL;
         end
      endcase
      step.phase_next = nxt;
      step.is_integer = (nxt == PH_INT);
      step.is_decimal = (nxt == PH_INT) || (nxt == PH_FRAC) || (nxt == PH_EXP);
   end

endmodule

// ===== src/number_literal_syntax_check.sv =====
// ----------------------------------------------------------------------------
// number_literal_syntax_check
// Streams a string byte by byte and flags whether it is an integer and
// whether it is a decimal number.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per string byte. req_tdata[7:0] is the byte, req_tlast
//            marks the final byte, req_tuser[0] marks a zero-length string
//            (its byte is ignored; it yields one all-zero result and drops
//            any unfinished string).
//   rsp_*  : one beat per finished string. rsp_tdata[0] = is_integer,
//            rsp_tdata[1] = is_decimal, upper bits zero.
//   Throughput: one byte per cycle, sustained, with rsp_tready held high.
//   Path: a last byte passes through the input register, then the
//   phase/result register, before its result shows at rsp_*.
//   The phase register feeds back through nlsc_step combinationally, which
//   is what allows the next byte of the same string in the next cycle.
//   Stall: while the result register is full and rsp_tready is low, the input
//   register keeps one byte and req_tready drops once it is occupied; bytes
//   that give no result still drain, since they only touch the phase.
//   Reset (synchronous, active high) empties both registers and returns the
//   grammar walk to the start of a string.
// ----------------------------------------------------------------------------
module number_literal_syntax_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [nlsc_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] char_code
   input  logic                               req_tlast,   // last_char
   input  logic [0:0]                         req_tuser,   // [0] empty_string
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [nlsc_pkg::RSP_DATA_W-1:0]    rsp_tdata    // [0] is_integer,
                                                           // [1] is_decimal
);
   import nlsc_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       in_empty_ff;

   // phase and result registers
   phase_type  phase_ff, phase_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_int_ff, out_int_in;
   logic       out_dec_ff, out_dec_in;

   step_type   step;
   logic       ends_string;
   logic       proceed;
   logic       req_fire;

   nlsc_step u_step (
      .phase     (phase_ff),
      .char_code (in_char_ff),
      .step      (step)
   );

   assign ends_string = in_last_ff || in_empty_ff;
   // a result-producing beat needs a free (or draining) result slot
   assign proceed     = in_valid_ff && (!ends_string || !out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || proceed;
   assign req_fire    = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (proceed ? 1'b0 : in_valid_ff);
      phase_in     = phase_ff;
      out_valid_in = (rsp_tready) ? 1'b0 : out_valid_ff;
      out_int_in   = out_int_ff;
      out_dec_in   = out_dec_ff;
      if (proceed) begin
         if (in_empty_ff) begin
            phase_in     = PH_START;
            out_valid_in = 1'b1;
            out_int_in   = 1'b0;
            out_dec_in   = 1'b0;
         end else if (in_last_ff) begin
            phase_in     = PH_START;
            out_valid_in = 1'b1;
            out_int_in   = step.is_integer;
            out_dec_in   = step.is_decimal;
         end else begin
            phase_in     = step.phase_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff  <= req_tdata[7:0];
         in_last_ff  <= req_tlast;
         in_empty_ff <= req_tuser[0];
      end
      out_int_ff <= out_int_in;
      out_dec_ff <= out_dec_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2){1'b0}}, out_dec_ff, out_int_ff};

   // end of string returns the walk to its start
   a_restart: assert property (@(posedge clock) disable iff (reset)
      proceed && ends_string |=> phase_ff == PH_START)
      else $error("phase not restarted after end of string");

   // an empty string item reports false for both tests
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      proceed && in_empty_ff |=> rsp_tvalid && !rsp_tdata[0] && !rsp_tdata[1])
      else $error("empty string gave a nonzero result");

   // every integer is also a decimal
   a_int_is_dec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("integer flagged without decimal");

   // a beat that gives no result never stalls
   a_no_stall_mid: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !ends_string |-> proceed)
      else $error("mid-string byte stalled");

   // a pending result with a stalled receiver holds its verdict
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for the number literal syntax checker.
// Strings go in one byte beat at a time. A scoreboard walks its own copy of
// the decimal grammar for every accepted beat and queues one integer/decimal
// verdict for each finished string. Each result beat is checked against the
// oldest queued verdict. Both sides idle in random bursts. One long receiver
// hold-off backs the block up, and there are full drains between phases.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nlsc_pkg::*;

   localparam int unsigned RANDOM_BEATS = 1000;  // random part stops past this
   localparam int unsigned QUIET_BEATS  = 150;   // tail of the run with no idling
   localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int unsigned DRAIN_LIMIT  = 4000;  // cycles allowed for the final drain

   typedef logic [7:0] text_type[$];

   // One verdict per finished string.
   typedef struct packed {
      logic is_integer;
      logic is_decimal;
   } verdict_type;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks grammar position and queues verdicts
   // -------------------------------------------------------------------------
   class literal_verdicts;
      phase_type   walk_phase = PH_START;
      verdict_type verdicts_due[$];
      int unsigned errors = 0;
      int unsigned strings_done = 0;
      int unsigned empties = 0;
      int unsigned ints_seen = 0;
      int unsigned decs_seen = 0;

      task report(input string msg);
         errors++;
         $display("ERROR @%0t: %s", $time, msg);
      endtask

      // One step of the decimal grammar. A sign or digit at the start falls
      // through to the next rule, as does a sign after the exponent mark.
      function phase_type step_grammar(input phase_type ph, input logic [7:0] c);
         logic is_digit;
         is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         case (ph)
            PH_START, PH_PLUS, PH_MINUS, PH_INT: begin
               if (ph == PH_START && c == CHAR_PLUS) return PH_PLUS;
               if ((ph == PH_START || ph == PH_PLUS) && c == CHAR_MINUS) return PH_MINUS;
               if (is_digit) return PH_INT;
               if (c == CHAR_DOT) return PH_DOT;
               if (c == CHAR_E) return PH_E;
               return PH_FAIL;
            end
            PH_DOT, PH_FRAC: begin
               if (is_digit) return PH_FRAC;
               if (c == CHAR_E) return PH_E;
               return PH_FAIL;
            end
            PH_E, PH_EPLUS, PH_EMINUS, PH_EXP: begin
               if (ph == PH_E && c == CHAR_PLUS) return PH_EPLUS;
               if ((ph == PH_E || ph == PH_EPLUS) && c == CHAR_MINUS) return PH_EMINUS;
               if (is_digit) return PH_EXP;
               return PH_FAIL;
            end
            default: return PH_FAIL;
         endcase
      endfunction

      // Accepted input beat.
      function void note_byte(input logic [7:0] c, input logic last, input logic empty);
         verdict_type v;
         if (empty) begin
            // zero-length string: drops any partial string, verdict all-zero
            v = '0;
            verdicts_due.push_back(v);
            walk_phase = PH_START;
            empties++;
            return;
         end
         walk_phase = step_grammar(walk_phase, c);
         if (!last) return;
         v.is_integer = (walk_phase == PH_INT);
         v.is_decimal = (walk_phase == PH_INT) || (walk_phase == PH_FRAC) ||
                        (walk_phase == PH_EXP);
         verdicts_due.push_back(v);
         walk_phase = PH_START;
      endfunction

      // Accepted result beat.
      task check_verdict(input logic [RSP_DATA_W-1:0] data);
         verdict_type v;
         if (verdicts_due.size() == 0) begin
            report($sformatf("result beat 0x%02h with no string pending", data));
            return;
         end
         v = verdicts_due.pop_front();
         strings_done++;
         ints_seen += v.is_integer;
         decs_seen += v.is_decimal;
         if (data[0] !== v.is_integer)
            report($sformatf("is_integer got %b want %b", data[0], v.is_integer));
         if (data[1] !== v.is_decimal)
            report($sformatf("is_decimal got %b want %b", data[1], v.is_decimal));
         if (data[RSP_DATA_W-1:2] !== '0)
            report($sformatf("pad bits nonzero, tdata 0x%02h", data));
      endtask

      function int unsigned pending();
         return verdicts_due.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // [7:0] char_code
   logic                  req_tlast  = 1'b0;  // last_char
   logic [0:0]            req_tuser  = '0;    // [0] empty_string
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [0] is_integer, [1] is_decimal

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   number_literal_syntax_check u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   literal_verdicts sb = new();

   // Shared controls for the stimulus and the receiver.
   bit          idle_on     = 1'b1;  // random idle bursts allowed on both sides
   bit          hold_rsp    = 1'b0;  // request a long receiver hold-off
   bit          rsp_holding = 1'b0;  // receiver is in the hold-off
   int unsigned beats_sent  = 0;

   // -------------------------------------------------------------------------
   // Monitor: sample both handshakes at the edge. Results are checked before
   // the same edge's input is noted. A verdict can never come back in the
   // cycle its last byte goes in.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_verdict(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_byte(req_tdata[7:0], req_tlast, req_tuser[0]);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: alternates ready and stall bursts. On request it holds off
   // for the long hold-off so the block backs up into its input.
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned n;
      forever begin
         if (hold_rsp) begin
            rsp_tready  <= 1'b0;
            rsp_holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_holding = 1'b0;
            hold_rsp    = 1'b0;
         end else if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge clock);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // One beat, with an optional idle burst in front. Returns at the edge
   // where the beat was taken.
   task automatic send_beat(input logic [7:0] c, input logic last, input logic empty);
      int unsigned gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      req_tuser  <= empty;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // Zero-length string; the byte and the last mark carry no meaning.
   task automatic send_empty();
      send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   task automatic send_chars(input text_type t);
      if (t.size() == 0) begin
         send_empty();
         return;
      end
      foreach (t[i]) send_beat(t[i], i == t.size() - 1, 1'b0);
   endtask

   task automatic send_text(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      send_chars(t);
   endtask

   // Bytes that do not finish a string, then an empty beat that drops them.
   task automatic send_abandoned(input text_type t);
      int unsigned k;
      k = $urandom_range(1, t.size());
      for (int i = 0; i < k; i++) send_beat(t[i], 1'b0, 1'b0);
      send_empty();
   endtask

   // Stop sending until every queued verdict has come back. It waits on the clock
   // before it tests the queue, so the valid drop and the next beat are distinct steps.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Mostly grammar-shaped literals with random digits and optional parts;
   // a share gets a byte replaced or a marker inserted, some are pure noise.
   function automatic text_type make_literal();
      text_type    t;
      int unsigned n;
      logic [7:0]  marks[6];
      marks = '{CHAR_PLUS, CHAR_MINUS, CHAR_DOT, CHAR_E, CHAR_ZERO, CHAR_NINE};
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) t.push_back(8'($urandom_range(0, 255)));
         return t;
      end
      if ($urandom_range(0, 1)) t.push_back(CHAR_PLUS);
      if ($urandom_range(0, 1)) t.push_back(CHAR_MINUS);
      n = $urandom_range(0, 4);
      repeat (n) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) == 0) begin
         t.push_back(CHAR_DOT);
         n = $urandom_range(0, 3);
         repeat (n) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 2) == 0) begin
         t.push_back(CHAR_E);
         if ($urandom_range(0, 1)) t.push_back(CHAR_PLUS);
         if ($urandom_range(0, 1)) t.push_back(CHAR_MINUS);
         n = $urandom_range(0, 3);
         repeat (n) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      case ($urandom_range(0, 9))
         0: if (t.size() != 0) t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
         1: t.insert($urandom_range(0, t.size()), marks[$urandom_range(0, 5)]);
         default: ;
      endcase
      return t;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      string       directed[$];
      text_type    t;
      int unsigned strings_in_chunk;
      int unsigned n;
      bit          hold_done;
      bit          pause_done;

      directed = '{"0", "9", "/", ":", "123", "+-5", ".5", "e5", "5.e5", "5.", ".", "+",
                   "-", "+-", "-+5", "++1", "5e", "5e+-3", "5e-+3", "5E5", "12.34e-7",
                   "1.2.3"};
      hold_done  = 1'b0;
      pause_done = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: grammar quirks, trailing-sign and trailing-mark endings,
      // digit range edges, extreme bytes, empty strings with either last
      // mark, and a partial string dropped by an empty one.
      foreach (directed[i]) send_text(directed[i]);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hff, 1'b1, 1'b0);
      send_beat(8'hff, 1'b1, 1'b1);
      send_beat(8'h00, 1'b0, 1'b1);
      t = '{CHAR_ZERO + 8'd1, CHAR_ZERO + 8'd2};
      for (int i = 0; i < 2; i++) send_beat(t[i], 1'b0, 1'b0);
      send_empty();
      drain();

      // Random part. Idling is switched per chunk so there are stretches
      // with no gaps; the tail of the run has none at all.
      beats_sent       = 0;
      strings_in_chunk = 0;
      while (beats_sent < RANDOM_BEATS) begin
         if (beats_sent >= RANDOM_BEATS - QUIET_BEATS) begin
            idle_on = 1'b0;
         end else if (strings_in_chunk == 0) begin
            idle_on          = ($urandom_range(0, 3) != 0);
            strings_in_chunk = $urandom_range(10, 40);
         end else begin
            strings_in_chunk--;
         end

         // Long receiver hold-off while short strings keep coming, so the
         // result and input registers fill and the block stalls its input.
         // Valid drops while waiting for the hold-off so no beat repeats.
         if (!hold_done && beats_sent >= 300) begin
            hold_done = 1'b1;
            hold_rsp  = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (!rsp_holding);
            repeat (60) begin
               n = $urandom_range(1, 3);
               t = {};
               repeat (n) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
               send_chars(t);
            end
            continue;
         end

         // Sender stops once until every pending verdict has come back.
         if (!pause_done && beats_sent >= 600) begin
            pause_done = 1'b1;
            drain();
         end

         t = make_literal();
         case ($urandom_range(0, 19))
            0:       send_empty();
            1:       if (t.size() != 0) send_abandoned(t); else send_empty();
            default: send_chars(t);
         endcase
      end

      // Final drain, bounded, then let the pipeline settle.
      req_tvalid <= 1'b0;
      n = 0;
      while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (10) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d verdicts never came back", sb.pending()));

      $display("Covered: %0d strings checked, %0d integers, %0d decimals, %0d empty.",
               sb.strings_done, sb.ints_seen, sb.decs_seen, sb.empties);
      $display("Covered: idle bursts both sides, %0d-cycle receiver hold-off, full drains.",
               HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog, far past the slowest legal run.
   initial begin : watchdog
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule
